[rtl/r01_pkg.sv]
// Shared types and constants of the RAID 0+1 request splitter.
package r01_pkg;

    localparam int MAX_DEVICES = 16;
    localparam int DEV_W       = 4;
    localparam int ADDR_W      = 48;
    localparam int LEN_W       = 32;
    localparam int TIME_W      = 48;
    localparam int SU_W        = 25;
    localparam int CNT_W       = 5;
    localparam int QUO_W       = 49;
    localparam int CHILD_W     = 5;
    localparam int HALF_W      = 4;
    localparam int IDX_W       = 1;

    localparam logic [IDX_W-1:0] REG_STRIPE_UNIT  = 1'd0;
    localparam logic [IDX_W-1:0] REG_DEVICE_COUNT = 1'd1;

    localparam logic [SU_W-1:0]  SU_RESET  = 25'd4096;
    localparam logic [CNT_W-1:0] CNT_RESET = 5'd4;
    localparam logic [CNT_W-1:0] CNT_MIN   = 5'd2;
    localparam logic [CNT_W-1:0] CNT_MAX   = 5'd16;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] volume_address;
        logic [LEN_W-1:0]  byte_length;
        logic              is_write;
        logic [TIME_W-1:0] event_time;
        logic [DEV_W-1:0]  device_number;
    } item_t;

    typedef struct packed {
        logic [DEV_W-1:0]   device_index;
        logic [ADDR_W-1:0]  device_offset;
        logic [LEN_W-1:0]   extent_length;
        logic               write_kind;
        logic [CHILD_W-1:0] child_number;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0]      addr;
        logic [QUO_W-1:0]       last_byte;
        logic                   wr;
        logic [MAX_DEVICES-1:0] take;
        logic [HALF_W-1:0]      half;
        logic [SU_W-1:0]        su;
    } cmd_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV_SU,
        BK_WAIT_SU,
        BK_DIV_H,
        BK_WAIT_H,
        BK_COL,
        BK_MUL_LO,
        BK_MUL_HI,
        BK_MUL_LEN,
        BK_EMIT,
        BK_FIN
    } back_state_t;

endpackage

[rtl/r01_front.sv]
// Front end: configuration, failure table, read toggle and copy selection.
module r01_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic                      full,
    input  r01_pkg::item_t            item,
    input  logic                      cfg_write,
    input  logic [r01_pkg::IDX_W-1:0] cfg_index,
    input  logic [r01_pkg::SU_W-1:0]  cfg_data,
    output logic                      cmd_push,
    output r01_pkg::cmd_t             cmd
);

    logic [r01_pkg::SU_W-1:0]        su_reg;
    logic [r01_pkg::CNT_W-1:0]       cnt_reg;
    logic                            lower_reg;
    logic [r01_pkg::MAX_DEVICES-1:0] failed_reg;
    logic [r01_pkg::TIME_W-1:0]      ftime_reg [r01_pkg::MAX_DEVICES];

    logic                            accept;
    logic [r01_pkg::CNT_W-1:0]       cnt;
    logic [r01_pkg::HALF_W-1:0]      half;
    logic [r01_pkg::MAX_DEVICES-1:0] down;
    logic [r01_pkg::MAX_DEVICES-1:0] take;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            su_reg     <= r01_pkg::SU_RESET;
            cnt_reg    <= r01_pkg::CNT_RESET;
            lower_reg  <= 1'b1;
            failed_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    r01_pkg::REG_STRIPE_UNIT:  su_reg  <= cfg_data;
                    r01_pkg::REG_DEVICE_COUNT: cnt_reg <= cfg_data[r01_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (accept && item.func)
            begin
                failed_reg[item.device_number] <= 1'b1;
            end
            if (accept && !item.func && !item.is_write)
            begin
                lower_reg <= !lower_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.func)
        begin
            ftime_reg[item.device_number] <= item.event_time;
        end
    end

    always_comb
    begin
        logic [r01_pkg::DEV_W-1:0] pi;
        logic [r01_pkg::DEV_W-1:0] ci;
        cnt = cnt_reg;
        if (cnt < r01_pkg::CNT_MIN)
        begin
            cnt = r01_pkg::CNT_MIN;
        end
        if (cnt > r01_pkg::CNT_MAX)
        begin
            cnt = r01_pkg::CNT_MAX;
        end
        half = cnt[r01_pkg::CNT_W-1:1];
        for (int i = 0; i < r01_pkg::MAX_DEVICES; i++)
        begin
            down[i] = failed_reg[i] && (ftime_reg[i] <= item.event_time);
        end
        for (int i = 0; i < r01_pkg::MAX_DEVICES; i++)
        begin
            pi = r01_pkg::DEV_W'(i) + half;
            ci = r01_pkg::DEV_W'(i) - half;
            if (item.is_write)
            begin
                take[i] = !down[i];
            end
            else if (r01_pkg::CNT_W'(i) < {1'b0, half})
            begin
                take[i] = lower_reg ? !down[i] : down[pi];
            end
            else
            begin
                take[i] = lower_reg ? down[ci] : !down[i];
            end
        end
    end

    assign cmd_push       = accept && !item.func && (item.byte_length != '0);
    assign cmd.addr       = item.volume_address;
    assign cmd.last_byte  = {1'b0, item.volume_address}
                            + {17'b0, item.byte_length} - 49'd1;
    assign cmd.wr         = item.is_write;
    assign cmd.take       = take;
    assign cmd.half       = half;
    assign cmd.su         = (su_reg == '0) ? r01_pkg::SU_W'(1) : su_reg;

endmodule

[rtl/r01_cmd_queue.sv]
// Two-entry queue of classified requests between front and back.
module r01_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  r01_pkg::cmd_t push_data,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output r01_pkg::cmd_t head
);

    r01_pkg::cmd_t mem [2];
    logic          wp_reg;
    logic          rp_reg;
    logic [1:0]    count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= push_data;
        end
    end

endmodule

[rtl/r01_div.sv]
// Restoring divider, one quotient bit per cycle.
module r01_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [r01_pkg::QUO_W-1:0] dividend,
    input  logic [r01_pkg::SU_W-1:0]  divisor,
    output logic                      busy,
    output logic [r01_pkg::QUO_W-1:0] quotient,
    output logic [r01_pkg::SU_W-1:0]  remainder
);

    logic [r01_pkg::QUO_W-1:0] quo_reg;
    logic [r01_pkg::SU_W-1:0]  rem_reg;
    logic [r01_pkg::SU_W-1:0]  div_reg;
    logic [5:0]                cnt_reg;
    logic                      busy_reg;
    logic [r01_pkg::SU_W:0]    shifted;
    logic                      fits;

    assign shifted   = {rem_reg, quo_reg[r01_pkg::QUO_W-1]};
    assign fits      = shifted >= {1'b0, div_reg};
    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'(r01_pkg::QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? r01_pkg::SU_W'(shifted - {1'b0, div_reg})
                            : shifted[r01_pkg::SU_W-1:0];
            quo_reg <= {quo_reg[r01_pkg::QUO_W-2:0], fits};
        end
    end

endmodule

[rtl/r01_back.sv]
// Back end: stripe arithmetic, per-device extent sequencer and result queue.
module r01_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_empty,
    input  r01_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    input  logic             pop,
    output logic             empty,
    output r01_pkg::result_t result
);

    r01_pkg::back_state_t       state_reg;
    r01_pkg::back_state_t       state_next;
    r01_pkg::cmd_t              cmd_reg;
    logic [r01_pkg::SU_W-1:0]   ra_reg;
    logic [r01_pkg::SU_W-1:0]   rb_reg;
    logic [r01_pkg::DEV_W-1:0]  dev_reg;
    logic [r01_pkg::QUO_W-1:0]  row1_reg;
    logic [r01_pkg::LEN_W-1:0]  n_reg;
    logic [r01_pkg::SU_W-1:0]   head_reg;
    logic [r01_pkg::SU_W-1:0]   tail_reg;
    logic [r01_pkg::ADDR_W-1:0] off_reg;
    logic [r01_pkg::LEN_W-1:0]  len_reg;
    r01_pkg::result_t           pend_reg;
    logic                       pend_valid_reg;
    logic [r01_pkg::CHILD_W-1:0] child_reg;

    r01_pkg::result_t           oq [2];
    logic                       oq_wp_reg;
    logic                       oq_rp_reg;
    logic [1:0]                 oq_cnt_reg;
    logic                       oq_full;
    logic                       out_push;
    r01_pkg::result_t           out_data;
    logic                       out_pop;

    logic                       div_start;
    logic                       stage_h;
    logic                       busy_a;
    logic                       busy_b;
    logic [r01_pkg::QUO_W-1:0]  quo_a;
    logic [r01_pkg::QUO_W-1:0]  quo_b;
    logic [r01_pkg::SU_W-1:0]   rem_a;
    logic [r01_pkg::SU_W-1:0]   rem_b;
    logic [r01_pkg::SU_W-1:0]   divisor;

    logic [r01_pkg::DEV_W-1:0]  col;
    logic [r01_pkg::HALF_W-1:0] r0;
    logic [r01_pkg::HALF_W-1:0] rl;
    logic                       lo_bump;
    logic                       hi_drop;
    logic [r01_pkg::QUO_W-1:0]  row1;
    logic [r01_pkg::QUO_W-1:0]  row2;
    logic                       col_ok;
    logic                       last_dev;
    logic [31:0]                mul_a;
    logic [56:0]                prod;

    assign stage_h   = (state_reg == r01_pkg::BK_DIV_H);
    assign div_start = (state_reg == r01_pkg::BK_DIV_SU) || stage_h;
    assign divisor   = stage_h ? {21'b0, cmd_reg.half} : cmd_reg.su;

    r01_div u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (stage_h ? quo_a : {1'b0, cmd_reg.addr}),
        .divisor   (divisor),
        .busy      (busy_a),
        .quotient  (quo_a),
        .remainder (rem_a)
    );

    r01_div u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (stage_h ? quo_b : cmd_reg.last_byte),
        .divisor   (divisor),
        .busy      (busy_b),
        .quotient  (quo_b),
        .remainder (rem_b)
    );

    assign r0      = rem_a[r01_pkg::HALF_W-1:0];
    assign rl      = rem_b[r01_pkg::HALF_W-1:0];
    assign col     = (dev_reg < cmd_reg.half) ? dev_reg : dev_reg - cmd_reg.half;
    assign lo_bump = col < r0;
    assign hi_drop = col > rl;
    assign row1    = quo_a + {48'b0, lo_bump};
    assign row2    = quo_b - {48'b0, hi_drop};
    assign col_ok  = cmd_reg.take[dev_reg]
                     && (({1'b0, row1} + {49'b0, hi_drop}) <= {1'b0, quo_b});
    assign last_dev = ({1'b0, dev_reg} == ({cmd_reg.half, 1'b0} - 5'd1));

    always_comb
    begin
        case (state_reg)
            r01_pkg::BK_MUL_LO: mul_a = {8'b0, row1_reg[23:0]};
            r01_pkg::BK_MUL_HI: mul_a = {8'b0, row1_reg[47:24]};
            default:            mul_a = n_reg;
        endcase
    end

    assign prod = mul_a * cmd_reg.su;

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        out_push   = 1'b0;
        out_data   = pend_reg;
        unique case (state_reg)
            r01_pkg::BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    state_next = r01_pkg::BK_DIV_SU;
                end
            end
            r01_pkg::BK_DIV_SU: state_next = r01_pkg::BK_WAIT_SU;
            r01_pkg::BK_WAIT_SU:
            begin
                if (!busy_a && !busy_b)
                begin
                    state_next = r01_pkg::BK_DIV_H;
                end
            end
            r01_pkg::BK_DIV_H: state_next = r01_pkg::BK_WAIT_H;
            r01_pkg::BK_WAIT_H:
            begin
                if (!busy_a && !busy_b)
                begin
                    state_next = r01_pkg::BK_COL;
                end
            end
            r01_pkg::BK_COL:
            begin
                if (col_ok)
                begin
                    state_next = r01_pkg::BK_MUL_LO;
                end
                else if (last_dev)
                begin
                    state_next = r01_pkg::BK_FIN;
                end
            end
            r01_pkg::BK_MUL_LO: state_next = r01_pkg::BK_MUL_HI;
            r01_pkg::BK_MUL_HI: state_next = r01_pkg::BK_MUL_LEN;
            r01_pkg::BK_MUL_LEN: state_next = r01_pkg::BK_EMIT;
            r01_pkg::BK_EMIT:
            begin
                if (!(pend_valid_reg && oq_full))
                begin
                    out_push   = pend_valid_reg;
                    state_next = last_dev ? r01_pkg::BK_FIN : r01_pkg::BK_COL;
                end
            end
            r01_pkg::BK_FIN:
            begin
                out_data.last = 1'b1;
                if (!pend_valid_reg)
                begin
                    state_next = r01_pkg::BK_IDLE;
                end
                else if (!oq_full)
                begin
                    out_push   = 1'b1;
                    state_next = r01_pkg::BK_IDLE;
                end
            end
            default: state_next = r01_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= r01_pkg::BK_IDLE;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == r01_pkg::BK_EMIT && state_next != r01_pkg::BK_EMIT)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (state_reg == r01_pkg::BK_FIN)
            begin
                pend_valid_reg <= pend_valid_reg && oq_full;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            r01_pkg::BK_IDLE:
            begin
                cmd_reg <= cmd;
            end
            r01_pkg::BK_WAIT_SU:
            begin
                ra_reg <= rem_a;
                rb_reg <= rem_b;
            end
            r01_pkg::BK_WAIT_H:
            begin
                dev_reg   <= '0;
                child_reg <= r01_pkg::CHILD_W'(1);
            end
            r01_pkg::BK_COL:
            begin
                row1_reg <= row1;
                n_reg    <= row2[r01_pkg::LEN_W-1:0] - row1[r01_pkg::LEN_W-1:0] + 32'd1;
                head_reg <= (col == r0) ? ra_reg : '0;
                tail_reg <= (col == rl) ? cmd_reg.su - 25'd1 - rb_reg : '0;
                if (!col_ok)
                begin
                    dev_reg <= dev_reg + 4'd1;
                end
            end
            r01_pkg::BK_MUL_LO:
            begin
                off_reg <= prod[r01_pkg::ADDR_W-1:0] + {23'b0, head_reg};
            end
            r01_pkg::BK_MUL_HI:
            begin
                off_reg <= off_reg + {prod[23:0], 24'b0};
            end
            r01_pkg::BK_MUL_LEN:
            begin
                len_reg <= prod[r01_pkg::LEN_W-1:0] - {7'b0, head_reg} - {7'b0, tail_reg};
            end
            r01_pkg::BK_EMIT:
            begin
                if (state_next != r01_pkg::BK_EMIT)
                begin
                    pend_reg.device_index  <= dev_reg;
                    pend_reg.device_offset <= off_reg;
                    pend_reg.extent_length <= len_reg;
                    pend_reg.write_kind    <= cmd_reg.wr;
                    pend_reg.child_number  <= child_reg;
                    pend_reg.last          <= 1'b0;
                    child_reg              <= child_reg + 5'd1;
                    dev_reg                <= dev_reg + 4'd1;
                end
            end
            default: ;
        endcase
    end

    assign oq_full = (oq_cnt_reg == 2'd2);
    assign empty   = (oq_cnt_reg == 2'd0);
    assign result  = oq[oq_rp_reg];
    assign out_pop = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wp_reg  <= 1'b0;
            oq_rp_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (out_push)
            begin
                oq_wp_reg <= !oq_wp_reg;
            end
            if (out_pop)
            begin
                oq_rp_reg <= !oq_rp_reg;
            end
            oq_cnt_reg <= oq_cnt_reg + {1'b0, out_push} - {1'b0, out_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            oq[oq_wp_reg] <= out_data;
        end
    end

endmodule

[rtl/raid01_request_splitter.sv]
// Top level of the RAID 0+1 request splitter.
// A request is classified at once on acceptance; failure events update the
// table at acceptance and produce no beat. In the back end a request then
// goes through two serial 49-bit divisions (by the stripe unit, then by the
// half count) in a pair of one-bit-per-cycle dividers, a check of each device
// column, and for each extent the low, high and length products of the shared
// 32x25 multiplier before its emit step. A two-entry request queue lets the
// front take items while the back works; result beats wait in a two-entry queue.
module raid01_request_splitter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  r01_pkg::item_t            item,
    output logic                      empty,
    input  logic                      pop,
    output r01_pkg::result_t          result,
    input  logic                      cfg_write,
    input  logic [r01_pkg::IDX_W-1:0] cfg_index,
    input  logic [r01_pkg::SU_W-1:0]  cfg_data
);

    logic          cmd_push;
    r01_pkg::cmd_t cmd_in;
    logic          cmd_pop;
    logic          cmd_empty;
    r01_pkg::cmd_t cmd_head;

    r01_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    r01_cmd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .full      (full),
        .empty     (cmd_empty),
        .head      (cmd_head)
    );

    r01_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule
